[hdl/dgts_pkg.sv]
// ----------------------------------------------------------------------------
// dgts_pkg
// Types, codes and sizes shared by the delayed gate task scheduler modules.
// ----------------------------------------------------------------------------
package dgts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int GATE_COUNT = 8;
  localparam int GATE_REGS  = 8;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DROP = 2'd2,
    CMD_FIND = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EMIT_STATUS,
    EMIT_FOUND,
    EMIT_HOLD
  } emit_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] time_value;
    logic [2:0]  gate;
    logic [15:0] wood_index;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        fired;
    logic [2:0]  out_gate;
    logic [15:0] out_index;
    logic [15:0] out_start;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start;
    logic [2:0]  gate;
    logic [15:0] item;
  } task_t;

  // controller -> datapath
  typedef struct packed {
    logic      latch;
    logic      ptr_inc;
    logic      insert;
    logic      remove;
    logic      hold_load;
    logic      emit;
    emit_sel_t emit_sel;
    status_t   emit_status;
    logic      emit_last;
    logic      tick_done;
  } dgts_ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic at_end;
    logic match;
    logic fire;
    logic same_tick;
    logic full;
    logic out_free;
    logic hold_vld;
  } dgts_sts_t;

endpackage

[hdl/dgts_ctrl.sv]
// ----------------------------------------------------------------------------
// dgts_ctrl
// Command sequencer: takes one item, walks the list one entry per cycle unless
// a firing awaits output, and has the datapath insert, remove, hold and emit.
// ----------------------------------------------------------------------------
module dgts_ctrl
  import dgts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dgts_sts_t sts,
  output dgts_ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        unique case (sts.cmd)
          CMD_ADD: begin
            if (sts.out_free) begin
              ctl.emit        = 1'b1;
              ctl.emit_sel    = EMIT_STATUS;
              ctl.emit_status = sts.full ? STAT_FULL : STAT_OK;
              ctl.emit_last   = 1'b1;
              ctl.insert      = !sts.full;
              state_nxt       = ST_IDLE;
            end
          end
          CMD_DROP, CMD_FIND: begin
            priority if (sts.at_end) begin
              if (sts.out_free) begin
                ctl.emit        = 1'b1;
                ctl.emit_sel    = EMIT_STATUS;
                ctl.emit_status = STAT_MISS;
                ctl.emit_last   = 1'b1;
                state_nxt       = ST_IDLE;
              end
            end else if (sts.match) begin
              if (sts.out_free) begin
                ctl.emit        = 1'b1;
                ctl.emit_sel    = (sts.cmd == CMD_FIND) ? EMIT_FOUND : EMIT_STATUS;
                ctl.emit_status = STAT_OK;
                ctl.emit_last   = 1'b1;
                ctl.remove      = (sts.cmd == CMD_DROP);
                state_nxt       = ST_IDLE;
              end
            end else begin
              ctl.ptr_inc = 1'b1;
            end
          end
          CMD_TICK: begin
            priority if (sts.at_end || sts.same_tick) begin
              // flush the held firing as the final result, or report none
              if (sts.out_free) begin
                ctl.emit        = 1'b1;
                ctl.emit_sel    = sts.hold_vld ? EMIT_HOLD : EMIT_STATUS;
                ctl.emit_status = STAT_OK;
                ctl.emit_last   = 1'b1;
                ctl.tick_done   = 1'b1;
                state_nxt       = ST_IDLE;
              end
            end else if (sts.fire) begin
              // pass the previous firing on before holding this one
              if (!sts.hold_vld || sts.out_free) begin
                ctl.emit      = sts.hold_vld;
                ctl.emit_sel  = EMIT_HOLD;
                ctl.emit_last = 1'b0;
                ctl.hold_load = 1'b1;
                ctl.remove    = 1'b1;
              end
            end else begin
              ctl.ptr_inc = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_list_change: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.insert && ctl.remove))
    else $error("insert and remove issued together");

  a_scan_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> sts.out_free)
    else $error("result emitted over an untaken result");
`endif

endmodule

[hdl/dgts_dpath.sv]
// ----------------------------------------------------------------------------
// dgts_dpath
// Task list kept in newest-first order, gate delay registers, scan pointer,
// one elapsed-time comparator, held firing and the output register.
// ----------------------------------------------------------------------------
module dgts_dpath
  import dgts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dgts_ctl_t             ctl,
  output dgts_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  in_item_t         item_r;
  task_t            ent_r [TASK_SLOTS];
  logic [15:0]      delay_r [GATE_REGS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] ptr_r;
  logic [15:0]      last_tick_r;
  out_item_t        hold_r;
  out_item_t        hold_nxt;
  logic             hold_vld_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  task_t       cur;
  logic [15:0] elapsed;
  logic [15:0] gate_delay;
  task_t       new_ent;
  out_item_t   emit_data;

  assign cur     = ent_r[ptr_r[SLOT_W-1:0]];
  assign elapsed = item_r.time_value - cur.start;

  always_comb begin
    gate_delay = '0;
    if ({1'b0, cur.gate} < 4'(GATE_COUNT)) begin
      gate_delay = delay_r[cur.gate];
    end
  end

  assign sts.cmd       = item_r.cmd;
  assign sts.at_end    = (ptr_r == cnt_r);
  assign sts.match     = (cur.item == item_r.wood_index);
  assign sts.fire      = (elapsed >= gate_delay);
  assign sts.same_tick = (item_r.time_value == last_tick_r);
  assign sts.full      = (cnt_r == CNT_W'(TASK_SLOTS));
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.hold_vld  = hold_vld_r;

  assign new_ent.start = item_r.time_value;
  assign new_ent.gate  = item_r.gate;
  assign new_ent.item  = item_r.wood_index;

  always_comb begin
    emit_data        = '0;
    emit_data.status = ctl.emit_status;
    emit_data.last   = ctl.emit_last;
    unique case (ctl.emit_sel)
      EMIT_STATUS: begin
      end
      EMIT_FOUND: begin
        emit_data.out_gate  = cur.gate;
        emit_data.out_index = cur.item;
        emit_data.out_start = cur.start;
      end
      EMIT_HOLD: begin
        emit_data      = hold_r;
        emit_data.last = ctl.emit_last;
      end
      default: begin
      end
    endcase
  end

  // firing taken from the entry under the scan pointer
  always_comb begin
    hold_nxt           = '0;
    hold_nxt.status    = STAT_OK;
    hold_nxt.fired     = 1'b1;
    hold_nxt.out_gate  = cur.gate;
    hold_nxt.out_index = cur.item;
    hold_nxt.out_start = cur.start;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ptr_r       <= '0;
      last_tick_r <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < GATE_REGS; g++) begin
        delay_r[g] <= '0;
      end
    end else begin
      if (cfg_we) begin
        delay_r[cfg_index] <= cfg_data;
      end
      if (ctl.latch) begin
        ptr_r      <= '0;
        hold_vld_r <= 1'b0;
      end else if (ctl.ptr_inc) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (ctl.hold_load) begin
        hold_vld_r <= 1'b1;
      end
      if (ctl.insert) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (ctl.remove) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (ctl.tick_done) begin
        last_tick_r <= item_r.time_value;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_r <= in_data;
    end
    if (ctl.emit) begin
      out_data_r <= emit_data;
    end
    if (ctl.hold_load) begin
      hold_r <= hold_nxt;
    end
    if (ctl.insert) begin
      ent_r[0] <= new_ent;
      for (int q = 1; q < TASK_SLOTS; q++) begin
        ent_r[q] <= ent_r[q-1];
      end
    end else if (ctl.remove) begin
      // close the gap left at the scan pointer
      for (int q = 0; q < TASK_SLOTS - 1; q++) begin
        if (CNT_W'(q) >= ptr_r) begin
          ent_r[q] <= ent_r[q+1];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(TASK_SLOTS)) && (ptr_r <= cnt_r))
    else $error("task count or scan pointer out of range");

  a_remove_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.remove |-> !sts.at_end)
    else $error("remove issued past the end of the list");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the list");

  a_hold_is_firing: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && ctl.emit_sel == EMIT_HOLD) |-> (hold_vld_r && hold_r.fired))
    else $error("held firing emitted while empty");
`endif

endmodule

[hdl/delayed_gate_task_scheduler.sv]
// Add answers without a scan; drop and find scan to the first match or the list
// end, tick walks all pending tasks, and a repeated count scans none. Items are
// taken one at a time: in_stall stays high until the last result is emitted.
// The single comparator walks the task list one entry per cycle, unless a
// firing waits on a stalled output.
// Reset (synchronous, rst_n low): list empty, delays and last count zero.
// ----------------------------------------------------------------------------
// delayed_gate_task_scheduler
// Pool of pending gate tasks, newest first; add, drop, find and tick commands.
// ----------------------------------------------------------------------------
module delayed_gate_task_scheduler
  import dgts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dgts_ctl_t ctl;
  dgts_sts_t sts;

  dgts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  dgts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delayed gate task scheduler. A directed pass
// fills and overflows the task pool, looks up and drops duplicate indexes and
// fires tasks across the 16-bit count wrap. Random traffic then runs under
// three delay settings and three idle/stall mixes. A scoreboard class keeps
// its own copy of the task list and predicts every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import dgts_pkg::*;

  localparam int GATE_DELAY_BASE = 0;  // gateN_delay sits at index base + N
  localparam int RUN_LIMIT       = 5_000_000;

  // Pending-task list kept newest first; predicts the result stream.
  class gate_pool_tracker;
    logic [15:0] gate_delay [GATE_REGS];
    task_t       pool [$];
    logic [15:0] last_count;
    out_item_t   due_results [$];
    int n_cmds, n_adds, n_ticks, n_drops, n_finds;
    int n_fired, n_full, n_miss, n_checked, errors;

    function new();
      foreach (gate_delay[g]) gate_delay[g] = '0;
      last_count = '0;
      n_cmds = 0; n_adds = 0; n_ticks = 0; n_drops = 0; n_finds = 0;
      n_fired = 0; n_full = 0; n_miss = 0; n_checked = 0; errors = 0;
    endfunction

    function void set_delay(int g, logic [15:0] v);
      gate_delay[g] = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function logic [15:0] delay_for(logic [2:0] g);
      if (int'(g) >= GATE_COUNT) return '0;
      return gate_delay[g];
    endfunction

    function out_item_t status_only(status_t st);
      out_item_t r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
    endfunction

    function int newest_match(logic [15:0] idx);
      foreach (pool[p]) if (pool[p].item == idx) return p;
      return -1;
    endfunction

    function void schedule_command(in_item_t c);
      int p;
      task_t t;
      task_t due [$];
      out_item_t r;
      logic [15:0] elapsed;
      n_cmds++;
      case (c.cmd)
        CMD_ADD: begin
          n_adds++;
          if (pool.size() >= TASK_SLOTS) begin
            n_full++;
            due_results.push_back(status_only(STAT_FULL));
          end else begin
            t.start = c.time_value;
            t.gate  = c.gate;
            t.item  = c.wood_index;
            pool.push_front(t);
            due_results.push_back(status_only(STAT_OK));
          end
        end
        CMD_DROP, CMD_FIND: begin
          if (c.cmd == CMD_DROP) n_drops++;
          else n_finds++;
          p = newest_match(c.wood_index);
          if (p < 0) begin
            n_miss++;
            due_results.push_back(status_only(STAT_MISS));
          end else if (c.cmd == CMD_FIND) begin
            r = status_only(STAT_OK);
            r.out_gate  = pool[p].gate;
            r.out_index = pool[p].item;
            r.out_start = pool[p].start;
            due_results.push_back(r);
          end else begin
            pool.delete(p);
            due_results.push_back(status_only(STAT_OK));
          end
        end
        default: begin
          n_ticks++;
          // a repeated count fires nothing
          if (c.time_value != last_count) begin
            p = 0;
            while (p < pool.size()) begin
              t = pool[p];
              elapsed = c.time_value - t.start;
              if (elapsed >= delay_for(t.gate)) begin
                due.push_back(t);
                pool.delete(p);
              end else begin
                p++;
              end
            end
          end
          last_count = c.time_value;
          if (due.size() == 0) due_results.push_back(status_only(STAT_OK));
          foreach (due[k]) begin
            r = '0;
            r.status    = STAT_OK;
            r.fired     = 1'b1;
            r.out_gate  = due[k].gate;
            r.out_index = due[k].item;
            r.out_start = due[k].start;
            r.last      = (k == due.size() - 1);
            due_results.push_back(r);
            n_fired++;
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got st=%0d f=%0d g=%0d idx=%h start=%h l=%0d",
                 $time, got.status, got.fired, got.out_gate, got.out_index,
                 got.out_start, got.last);
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.status !== want.status || got.fired !== want.fired ||
          got.out_gate !== want.out_gate || got.out_index !== want.out_index ||
          got.out_start !== want.out_start || got.last !== want.last) begin
        errors++;
        $display("%0t: result mismatch, expected st=%0d f=%0d g=%0d idx=%h start=%h l=%0d",
                 $time, want.status, want.fired, want.out_gate, want.out_index,
                 want.out_start, want.last);
        $display("%0t:                    actual st=%0d f=%0d g=%0d idx=%h start=%h l=%0d",
                 $time, got.status, got.fired, got.out_gate, got.out_index,
                 got.out_start, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gate_pool_tracker book;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        calm;
  logic [15:0] now;

  delayed_gate_task_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_data);
  end

  function automatic in_item_t make_command(cmd_t cmd, logic [15:0] tv,
                                            logic [2:0] g, logic [15:0] idx);
    in_item_t c;
    c.cmd        = cmd;
    c.time_value = tv;
    c.gate       = g;
    c.wood_index = idx;
    return c;
  endfunction

  // Mostly a small index pool so drops and finds hit; full range now and then.
  function automatic logic [15:0] pick_index();
    if ($urandom_range(0, 99) < 80) return 16'($urandom_range(0, 23));
    return 16'($urandom);
  endfunction

  function automatic in_item_t next_random_command();
    int r;
    int step;
    logic [15:0] tv;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      if ($urandom_range(0, 99) < 85) tv = now - 16'($urandom_range(0, 20));
      else tv = 16'($urandom);
      return make_command(CMD_ADD, tv, 3'($urandom_range(0, 7)), pick_index());
    end else if (r < 70) begin
      // advance the count: repeat, small step, long step or jump anywhere
      step = $urandom_range(0, 9);
      if (step == 9) now = 16'($urandom);
      else if (step == 8) now = now + 16'($urandom_range(16, 300));
      else now = now + 16'(step);
      return make_command(CMD_TICK, now, 3'($urandom_range(0, 7)), 16'($urandom));
    end else if (r < 85) begin
      return make_command(CMD_DROP, 16'($urandom), 3'($urandom_range(0, 7)), pick_index());
    end
    return make_command(CMD_FIND, 16'($urandom), 3'($urandom_range(0, 7)), pick_index());
  endfunction

  task automatic send_item(input in_item_t c);
    while (!calm && ($urandom_range(0, 99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.schedule_command(c);
    @(negedge clk);
  endtask

  // Drop valid and let the block drain before touching its registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (TASK_SLOTS + 4) @(negedge clk);
  endtask

  task automatic load_gate_delays(input logic [15:0] d [GATE_REGS]);
    for (int g = 0; g < GATE_REGS; g++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(GATE_DELAY_BASE + g);
      cfg_data  <= d[g];
      book.set_delay(g, d[g]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    logic [15:0] idx;
    logic [15:0] st;
    send_item(make_command(CMD_FIND, 16'h0000, 3'd0, 16'h1234));
    send_item(make_command(CMD_TICK, 16'h0000, 3'd0, 16'h0000));
    // fill the pool: index extremes, one duplicated index, starts near the wrap
    for (int i = 0; i < TASK_SLOTS; i++) begin
      idx = (i == 0) ? 16'h0000 : (i == TASK_SLOTS - 1) ? 16'hFFFF :
            (i == 3 || i == 9) ? 16'h0055 : 16'h1000 + 16'(i);
      st  = (i == 1) ? 16'hFFFF : (i == 2) ? 16'hFFF0 :
            (i % 8 == 4) ? 16'h0004 : 16'(i * 2);
      send_item(make_command(CMD_ADD, st, 3'(i), idx));
    end
    send_item(make_command(CMD_ADD, 16'hABCD, 3'd7, 16'h7777));
    send_item(make_command(CMD_FIND, 16'h0000, 3'd0, 16'h0055));
    send_item(make_command(CMD_DROP, 16'h0000, 3'd0, 16'h0055));
    send_item(make_command(CMD_FIND, 16'hFFFF, 3'd7, 16'h0055));
    // count 3 wraps past the starts near 0xFFFF; delay 0xFFFF elapses at start 4
    send_item(make_command(CMD_TICK, 16'h0003, 3'd0, 16'h0000));
    send_item(make_command(CMD_TICK, 16'h0003, 3'd0, 16'h0000));
    send_item(make_command(CMD_TICK, 16'h8000, 3'd7, 16'hFFFF));
    send_item(make_command(CMD_DROP, 16'hFFFF, 3'd7, 16'h0055));
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) calm = (send_idle_pct + recv_stall_pct == 0) ||
                              ($urandom_range(0, 3) == 0);
      send_item(next_random_command());
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [15:0] d [GATE_REGS];
    book           = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    calm           = 1'b0;
    send_idle_pct  = 19;
    recv_stall_pct = 70;
    now            = 16'h8000;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    d = '{16'd0, 16'd1, 16'd5, 16'd100, 16'hFFFF, 16'd2, 16'd3, 16'd10};
    load_gate_delays(d);
    run_directed();
    settle();

    foreach (d[g]) d[g] = 16'($urandom_range(0, 12));
    load_gate_delays(d);
    run_random(132);
    settle();

    send_idle_pct  = 70;
    recv_stall_pct = 19;
    d = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'd0, 16'd0, 16'd0, 16'd0};
    for (int g = 4; g < GATE_REGS; g++) d[g] = 16'($urandom_range(0, 40));
    load_gate_delays(d);
    run_random(132);
    settle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (d[g]) begin
      case ($urandom_range(0, 5))
        0:       d[g] = 16'h0000;
        1:       d[g] = 16'hFFFF;
        2:       d[g] = 16'($urandom);
        default: d[g] = 16'($urandom_range(0, 30));
      endcase
    end
    load_gate_delays(d);
    run_random(132);

    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (2 * TASK_SLOTS + 8) @(posedge clk);

    $display("ran %0d commands: %0d add, %0d tick, %0d drop, %0d find; %0d results checked",
             book.n_cmds, book.n_adds, book.n_ticks, book.n_drops, book.n_finds,
             book.n_checked);
    $display("%0d tasks fired, %0d adds to a full pool, %0d lookup misses, 4 delay sets",
             book.n_fired, book.n_full, book.n_miss);
    if (book.errors == 0) begin
      $display("delayed_gate_task_scheduler test passed");
    end else begin
      $display("delayed_gate_task_scheduler test failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d results outstanding", book.pending());
    $display("delayed_gate_task_scheduler test failed");
    $finish;
  end

endmodule
